FILE: rtl/list_symmetric_difference_unit_macros.svh
// assertion macros for the list symmetric difference unit
// used by the checker bound to the top level; no other dependencies
`ifndef LIST_SYMMETRIC_DIFFERENCE_UNIT_MACROS_SVH
`define LIST_SYMMETRIC_DIFFERENCE_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LSD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("lsd check failed: same-cycle property");

// consequent must hold in the cycle after the antecedent
`define LSD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("lsd check failed: next-cycle property");

`endif

FILE: rtl/lsd_pkg.sv
// shared types and constants for the list symmetric difference unit
// no dependencies; imported by every module of the block
package lsd_pkg;

  // list depth and derived widths
  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  // command codes of an input transaction
  localparam logic [1:0] CMD_PUSH_A = 2'd0;
  localparam logic [1:0] CMD_PUSH_B = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic push_a;
    logic push_b;
    logic start_init;
    logic next_phase;
    logic scan_clr;
    logic scan_step;
    logic i_inc;
    logic take;
    logic emit_last;
  } lsd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic i_done;
    logic j_done;
    logic hit;
    logic pend_valid;
    logic out_free;
    logic phase;
  } lsd_status_t;

endpackage

FILE: rtl/lsd_dp.sv
// datapath: list memories, counts, scan indices, comparator and result register
// depends on lsd_pkg
module lsd_dp
  import lsd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  lsd_cmd_t                cmd,
  output lsd_status_t             sts,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_result_value,
  output logic                    out_is_last,
  output logic                    out_no_result,
  output logic                    out_overflowed
);

  logic [VAL_W-1:0] mem_a [DEPTH];
  logic [VAL_W-1:0] mem_b [DEPTH];
  logic [VAL_W-1:0] rd_a_r, rd_b_r;

  logic [CNT_W-1:0] count_a_r, count_a_nxt;
  logic [CNT_W-1:0] count_b_r, count_b_nxt;
  logic             dropped_r, dropped_nxt;
  logic             phase_r, phase_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic             cv_r;
  logic             hit_r, hit_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [VAL_W-1:0] pend_val_r;

  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r;
  logic             out_last_r, out_none_r, out_ovf_r;

  logic             a_room, b_room;
  logic [IDX_W-1:0] addr_a, addr_b;
  logic [VAL_W-1:0] rd_outer, rd_inner;
  logic [CNT_W-1:0] cnt_outer, cnt_inner;
  logic             hit_now, out_free, out_load;

  // room left in each list
  assign a_room = count_a_r < CNT_W'(DEPTH);
  assign b_room = count_b_r < CNT_W'(DEPTH);

  // outer list is a in the first phase, b in the second
  assign addr_a    = phase_r ? j_r[IDX_W-1:0] : i_r[IDX_W-1:0];
  assign addr_b    = phase_r ? i_r[IDX_W-1:0] : j_r[IDX_W-1:0];
  assign rd_outer  = phase_r ? rd_b_r : rd_a_r;
  assign rd_inner  = phase_r ? rd_a_r : rd_b_r;
  assign cnt_outer = phase_r ? count_b_r : count_a_r;
  assign cnt_inner = phase_r ? count_a_r : count_b_r;

  // membership hit including the compare now in flight
  assign hit_now  = hit_r | (cv_r & (rd_inner == rd_outer));
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (cmd.take && pend_v_r) || cmd.emit_last;

  // list memories with registered read
  always_ff @(posedge clk) begin
    if (cmd.push_a && a_room) begin
      mem_a[count_a_r[IDX_W-1:0]] <= in_value;
    end
    if (cmd.push_b && b_room) begin
      mem_b[count_b_r[IDX_W-1:0]] <= in_value;
    end
    rd_a_r <= mem_a[addr_a];
    rd_b_r <= mem_b[addr_b];
  end

  // counts and overflow flag
  always_comb begin
    count_a_nxt = count_a_r;
    count_b_nxt = count_b_r;
    dropped_nxt = dropped_r;
    if (cmd.push_a) begin
      if (a_room) count_a_nxt = count_a_r + CNT_W'(1);
      else        dropped_nxt = 1'b1;
    end
    if (cmd.push_b) begin
      if (b_room) count_b_nxt = count_b_r + CNT_W'(1);
      else        dropped_nxt = 1'b1;
    end
    if (cmd.emit_last) begin
      count_a_nxt = '0;
      count_b_nxt = '0;
      dropped_nxt = 1'b0;
    end
  end

  // scan indices, hit flag and pending result
  always_comb begin
    phase_nxt  = phase_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    hit_nxt    = hit_now;
    pend_v_nxt = pend_v_r;
    if (cmd.start_init) begin
      phase_nxt = 1'b0;
      i_nxt     = '0;
    end
    if (cmd.next_phase) begin
      phase_nxt = 1'b1;
      i_nxt     = '0;
    end
    if (cmd.i_inc) begin
      i_nxt = i_r + CNT_W'(1);
    end
    if (cmd.scan_clr) begin
      j_nxt   = '0;
      hit_nxt = 1'b0;
    end
    if (cmd.scan_step) begin
      j_nxt = j_r + CNT_W'(1);
    end
    if (cmd.take) begin
      pend_v_nxt = 1'b1;
    end
    if (cmd.emit_last) begin
      pend_v_nxt = 1'b0;
    end
  end

  // output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (out_load)                  out_valid_nxt = 1'b1;
  end

  // control state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r   <= '0;
      count_b_r   <= '0;
      dropped_r   <= 1'b0;
      phase_r     <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      cv_r        <= 1'b0;
      hit_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      dropped_r   <= dropped_nxt;
      phase_r     <= phase_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      cv_r        <= cmd.scan_step;
      hit_r       <= hit_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_val_r <= rd_outer;
    end
    if (out_load) begin
      out_value_r <= (cmd.emit_last && !pend_v_r) ? '0 : pend_val_r;
      out_last_r  <= cmd.emit_last;
      out_none_r  <= cmd.emit_last && !pend_v_r;
      out_ovf_r   <= dropped_r;
    end
  end

  // status back to the controller
  assign sts.i_done     = (i_r == cnt_outer);
  assign sts.j_done     = (j_r == cnt_inner);
  assign sts.hit        = hit_now;
  assign sts.pend_valid = pend_v_r;
  assign sts.out_free   = out_free;
  assign sts.phase      = phase_r;

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_is_last      = out_last_r;
  assign out_no_result    = out_none_r;
  assign out_overflowed   = out_ovf_r;

endmodule

FILE: rtl/lsd_ctrl.sv
// controller: sequences pushes, the two membership scans and the final result
// depends on lsd_pkg
module lsd_ctrl
  import lsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_cmd,
  output logic        in_stall,
  input  lsd_status_t sts,
  output lsd_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_OFETCH = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_FINAL  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       in_accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_cmd)
            CMD_PUSH_A: cmd.push_a = 1'b1;
            CMD_PUSH_B: cmd.push_b = 1'b1;
            CMD_START: begin
              cmd.start_init = 1'b1;
              state_nxt      = ST_OFETCH;
            end
            default: ;
          endcase
        end
      end
      ST_OFETCH: begin
        if (sts.i_done) begin
          if (!sts.phase) cmd.next_phase = 1'b1;
          else            state_nxt      = ST_FINAL;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts.j_done) cmd.scan_step = 1'b1;
        else             state_nxt     = ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (sts.hit) begin
          cmd.i_inc = 1'b1;
          state_nxt = ST_OFETCH;
        end else if (!sts.pend_valid || sts.out_free) begin
          cmd.take  = 1'b1;
          cmd.i_inc = 1'b1;
          state_nxt = ST_OFETCH;
        end else begin
          // result register still busy, hold the decision
          state_nxt = ST_DECIDE;
        end
      end
      ST_FINAL: begin
        if (sts.out_free) begin
          cmd.emit_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/list_symmetric_difference_unit.sv
// top level of the list symmetric difference unit
// depends on lsd_pkg, lsd_ctrl and lsd_dp
//
//   channel | ports                                   | direction
//   input   | in_valid in_stall in_cmd in_value       | push or start in
//   result  | out_valid out_stall out_result_value    | one element per transaction,
//           | out_is_last out_no_result out_overflowed| last one marked
//
// a start runs both membership scans, a single compare per cycle against a registered
// memory read while scanning, and the scan is held only while the result register is busy
// the input is stalled from a start until its final result is loaded
// reset is synchronous and clears counts, flags and the state machine
// a stalled result only holds the scan once a further result is ready while one is pending, and holds the final result
module list_symmetric_difference_unit
  import lsd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_cmd,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_result_value,
  output logic                    out_is_last,
  output logic                    out_no_result,
  output logic                    out_overflowed
);

  lsd_cmd_t    cmd;
  lsd_status_t sts;

  // sequencing
  lsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage, compare and result register
  lsd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_value         (in_value),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_is_last      (out_is_last),
    .out_no_result    (out_no_result),
    .out_overflowed   (out_overflowed)
  );

endmodule

FILE: rtl/lsd_checker.sv
// port-level checks for the list symmetric difference unit, bound to the top
// depends on lsd_pkg and list_symmetric_difference_unit_macros.svh
`include "list_symmetric_difference_unit_macros.svh"

module lsd_checker
  import lsd_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [1:0]              in_cmd,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [VAL_W-1:0] out_result_value,
  input logic                    out_is_last,
  input logic                    out_no_result
);

  // a stalled result stays offered
  `LSD_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && out_stall, out_valid)

  // an empty answer is always the last of its start
  `LSD_ASSERT_NOW(a_empty_last, clk, rst_n, out_valid && out_no_result, out_is_last)

  // an empty answer carries a zero value
  `LSD_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && out_no_result, out_result_value == 0)

  // an accepted start blocks the input while the scan runs
  `LSD_ASSERT_NEXT(a_start_stall, clk, rst_n, in_valid && !in_stall && in_cmd == CMD_START, in_stall)

endmodule

bind list_symmetric_difference_unit lsd_checker u_lsd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_cmd           (in_cmd),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_value (out_result_value),
  .out_is_last      (out_is_last),
  .out_no_result    (out_no_result)
);
